// ===== hdl/esco_pkg.sv =====
// Shared types, field widths and helpers for the empty-space cell occupancy block.
// Used by the channel interfaces and by every module of the block; depends on nothing.
`default_nettype none

package esco_pkg;

  // Field widths of the channels
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned SUM_W     = 11;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Internal widths, sized for the whole legal range of MAX_DIM and GRID
  localparam int unsigned DIM_W  = 9;   // effective size, up to 256
  localparam int unsigned CRD_W  = 14;  // cell bound on one axis
  localparam int unsigned PROD_W = 15;  // (c+1)*dim + GRID-1

  // Parameter defaults
  localparam int unsigned MAX_DIM_DEF     = 64;
  localparam int unsigned GRID_DEF        = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Sampling stride inside a cell and the saturation level of the sum
  localparam int unsigned      STRIDE  = 3;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Commands of an input item; the same codes tag queue entries
  typedef enum logic [CMD_W-1:0] {
    CMD_VOXEL = 2'd0,
    CMD_ALPHA = 2'd1,
    CMD_TEST  = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DEPTH  = 2'd2
  } reg_e;

  // Queue entry between front and back.
  // Test: cell bounds per axis. Voxel write: voxel coordinate in lo_*.
  // Alpha write: table index in lo_x.
  typedef struct packed {
    cmd_e             op;
    logic [CRD_W-1:0] lo_x;
    logic [CRD_W-1:0] lo_y;
    logic [CRD_W-1:0] lo_z;
    logic [CRD_W-1:0] hi_x;
    logic [CRD_W-1:0] hi_y;
    logic [CRD_W-1:0] hi_z;
    logic [VAL_W-1:0] value;
  } q_entry_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Size register to effective size: zero reads as 1, large values clip to max_dim
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] v;
    v = DIM_W'(r);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (v > max_dim) begin
      return max_dim;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/esco_if.sv =====
// Channel interfaces of the cell occupancy block: input items, results, config writes.
// Depends on esco_pkg for the field widths.
`default_nettype none

interface esco_in_if;
  import esco_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic [IDX_W-1:0] table_index;
  logic [VAL_W-1:0] value;

  modport source (output valid, cmd, pos_x, pos_y, pos_z, table_index, value,
                  input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pos_z, table_index, value,
                  output ready);
endinterface

interface esco_out_if;
  import esco_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] opacity_sum;
  logic             occupied;

  modport source (output valid, opacity_sum, occupied, input ready);
  modport sink   (input valid, opacity_sum, occupied, output ready);
endinterface

interface esco_cfg_if;
  import esco_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/esco_front.sv =====
// Front end: accepts input items, drops ignored ones and turns a cell test into
// per-axis voxel bounds in two pipeline stages. Depends on esco_pkg and esco_in_if.
`default_nettype none

module esco_front #(
  parameter int unsigned MAX_DIM = esco_pkg::MAX_DIM_DEF,
  parameter int unsigned GRID    = esco_pkg::GRID_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  esco_in_if.sink                     in_i,
  input  logic [esco_pkg::DIM_W-1:0]  dim_x_i,
  input  logic [esco_pkg::DIM_W-1:0]  dim_y_i,
  input  logic [esco_pkg::DIM_W-1:0]  dim_z_i,
  output logic                        push_o,
  output esco_pkg::q_entry_t          entry_o,
  input  esco_pkg::q_stat_t           qstat_i
);
  import esco_pkg::*;

  // Division by GRID as multiply by reciprocal; exact for numerators below 2^PROD_W
  localparam int unsigned      SHIFT   = PROD_W + $clog2(GRID);
  localparam longint unsigned  RECIP   = ((longint'(1) << SHIFT) + GRID - 1) / GRID;
  localparam int unsigned      RECIP_W = PROD_W + 1;
  localparam int unsigned      MUL_W   = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [PROD_W-1:0]  ROUND_V = PROD_W'(GRID - 1);

  logic [POS_W-1:0]  pos_a   [3];
  logic [DIM_W-1:0]  dim_a   [3];
  logic [PROD_W-1:0] nlo_d   [3];
  logic [PROD_W-1:0] nhi_d   [3];
  logic [MUL_W-1:0]  mul_lo  [3];
  logic [MUL_W-1:0]  mul_hi  [3];

  logic              keep;
  logic              in_range;
  logic              s1_load;
  logic              s2_load;

  logic              s1_valid_q;
  cmd_e              s1_op_q;
  logic [PROD_W-1:0] s1_nlo_q [3];
  logic [PROD_W-1:0] s1_nhi_q [3];
  logic [VAL_W-1:0]  s1_val_q;

  logic              s2_valid_q;
  q_entry_t          s2_entry_q;
  q_entry_t          s2_entry_d;

  // Stall chain: queue -> stage 2 -> stage 1 -> input
  assign push_o     = s2_valid_q && !qstat_i.full;
  assign s2_load    = !s2_valid_q || push_o;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_i.ready = s1_load;
  assign entry_o    = s2_entry_q;

  // Classify: unused command and voxel writes outside the store are dropped
  assign in_range = (DIM_W'(in_i.pos_x) < DIM_W'(MAX_DIM)) &&
                    (DIM_W'(in_i.pos_y) < DIM_W'(MAX_DIM)) &&
                    (DIM_W'(in_i.pos_z) < DIM_W'(MAX_DIM));

  always_comb begin
    case (cmd_e'(in_i.cmd))
      CMD_VOXEL: begin
        keep = in_range;
      end
      CMD_ALPHA: begin
        keep = 1'b1;
      end
      CMD_TEST: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Stage 1: c*dim and (c+1)*dim + GRID-1 per axis; writes carry their address
  always_comb begin
    pos_a[0] = in_i.pos_x;
    pos_a[1] = in_i.pos_y;
    pos_a[2] = in_i.pos_z;
    dim_a[0] = dim_x_i;
    dim_a[1] = dim_y_i;
    dim_a[2] = dim_z_i;
    for (int a = 0; a < 3; a++) begin
      if (cmd_e'(in_i.cmd) == CMD_TEST) begin
        nlo_d[a] = PROD_W'(pos_a[a]) * PROD_W'(dim_a[a]);
        nhi_d[a] = (PROD_W'(pos_a[a]) + PROD_W'(1)) * PROD_W'(dim_a[a]) + ROUND_V;
      end else begin
        nlo_d[a] = PROD_W'(pos_a[a]);
        nhi_d[a] = '0;
      end
    end
    if (cmd_e'(in_i.cmd) == CMD_ALPHA) begin
      nlo_d[0] = PROD_W'(in_i.table_index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q  <= cmd_e'(in_i.cmd);
      s1_nlo_q <= nlo_d;
      s1_nhi_q <= nhi_d;
      s1_val_q <= in_i.value;
    end
  end

  // Stage 2: quotients by GRID give lo and hi bounds
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mul_lo[a] = MUL_W'(s1_nlo_q[a]) * MUL_W'(RECIP_V);
      mul_hi[a] = MUL_W'(s1_nhi_q[a]) * MUL_W'(RECIP_V);
    end
    s2_entry_d.op    = s1_op_q;
    s2_entry_d.value = s1_val_q;
    if (s1_op_q == CMD_TEST) begin
      s2_entry_d.lo_x = CRD_W'(mul_lo[0] >> SHIFT);
      s2_entry_d.lo_y = CRD_W'(mul_lo[1] >> SHIFT);
      s2_entry_d.lo_z = CRD_W'(mul_lo[2] >> SHIFT);
      s2_entry_d.hi_x = CRD_W'(mul_hi[0] >> SHIFT);
      s2_entry_d.hi_y = CRD_W'(mul_hi[1] >> SHIFT);
      s2_entry_d.hi_z = CRD_W'(mul_hi[2] >> SHIFT);
    end else begin
      s2_entry_d.lo_x = CRD_W'(s1_nlo_q[0]);
      s2_entry_d.lo_y = CRD_W'(s1_nlo_q[1]);
      s2_entry_d.lo_z = CRD_W'(s1_nlo_q[2]);
      s2_entry_d.hi_x = '0;
      s2_entry_d.hi_y = '0;
      s2_entry_d.hi_z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_entry_q <= s2_entry_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/esco_queue.sv =====
// Small FIFO of decoded items between the front end and the back end.
// Depends on esco_pkg for the entry and status types.
`default_nettype none

module esco_queue #(
  parameter int unsigned DEPTH = esco_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  esco_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output esco_pkg::q_entry_t entry_o,
  output esco_pkg::q_stat_t  stat_o
);
  import esco_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  q_entry_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign entry_o      = mem_q[rd_ptr_q];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/esco_back.sv =====
// Back end: holds the voxel store and alpha table, performs writes and walks the
// samples of a cell test, one voxel read per cycle. Depends on esco_pkg, esco_out_if.
`default_nettype none

module esco_back #(
  parameter int unsigned MAX_DIM = esco_pkg::MAX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  esco_pkg::q_entry_t         entry_i,
  input  esco_pkg::q_stat_t          qstat_i,
  output logic                       pop_o,
  input  logic [esco_pkg::DIM_W-1:0] dim_x_i,
  input  logic [esco_pkg::DIM_W-1:0] dim_y_i,
  input  logic [esco_pkg::DIM_W-1:0] dim_z_i,
  esco_out_if.source                 out_o
);
  import esco_pkg::*;

  localparam int unsigned AW          = $clog2(MAX_DIM);
  localparam int unsigned VOX_AW      = 3 * AW;
  localparam int unsigned VOX_DEPTH   = 1 << VOX_AW;
  localparam int unsigned ALPHA_DEPTH = 1 << VAL_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Stores
  logic [VAL_W-1:0] voxel_mem [VOX_DEPTH];
  logic [VAL_W-1:0] alpha_mem [ALPHA_DEPTH];
  logic [VAL_W-1:0] vox_rd_q;
  logic [VAL_W-1:0] alp_rd_q;

  // Scan position and bounds
  logic [CRD_W-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic [CRD_W-1:0] lo_y_q, lo_z_q;
  logic [CRD_W-1:0] hi_x_q, hi_y_q, hi_z_q;
  logic [CRD_W:0]   x_nx, y_nx, z_nx;
  logic             x_wrap, y_wrap, z_wrap;
  logic [CRD_W-1:0] lim_x, lim_y, lim_z;
  logic [CRD_W-1:0] sx, sy, sz;
  logic [VOX_AW-1:0] rd_addr;
  logic [VOX_AW-1:0] wr_addr;

  logic             vox_we, alp_we, vox_re;
  logic             vox_v_q, alp_v_q;
  logic             start;
  logic             finish;
  logic             out_free;

  logic [SUM_W-1:0] sum_q;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  logic             out_valid_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_occ_q;

  // Queue pop and write decode
  assign pop_o   = (state_q == ST_IDLE) && !qstat_i.empty;
  assign vox_we  = pop_o && (entry_i.op == CMD_VOXEL);
  assign alp_we  = pop_o && (entry_i.op == CMD_ALPHA);
  assign start   = pop_o && (entry_i.op == CMD_TEST);
  assign wr_addr = {entry_i.lo_z[AW-1:0], entry_i.lo_y[AW-1:0], entry_i.lo_x[AW-1:0]};

  // Clamp each sample coordinate to dim-1
  always_comb begin
    lim_x   = CRD_W'(dim_x_i - DIM_W'(1));
    lim_y   = CRD_W'(dim_y_i - DIM_W'(1));
    lim_z   = CRD_W'(dim_z_i - DIM_W'(1));
    sx      = (cur_x_q > lim_x) ? lim_x : cur_x_q;
    sy      = (cur_y_q > lim_y) ? lim_y : cur_y_q;
    sz      = (cur_z_q > lim_z) ? lim_z : cur_z_q;
    rd_addr = {sz[AW-1:0], sy[AW-1:0], sx[AW-1:0]};
  end

  // Next sample: z innermost, x outermost, stride of three
  always_comb begin
    x_nx   = {1'b0, cur_x_q} + (CRD_W+1)'(STRIDE);
    y_nx   = {1'b0, cur_y_q} + (CRD_W+1)'(STRIDE);
    z_nx   = {1'b0, cur_z_q} + (CRD_W+1)'(STRIDE);
    x_wrap = x_nx > {1'b0, hi_x_q};
    y_wrap = y_nx > {1'b0, hi_y_q};
    z_wrap = z_nx > {1'b0, hi_z_q};
  end

  assign vox_re   = (state_q == ST_SCAN);
  assign out_free = !out_valid_q || out_o.ready;
  assign finish   = (state_q == ST_DRAIN) && !vox_v_q && !alp_v_q && out_free;

  // Saturating accumulate
  always_comb begin
    sum_wide = {1'b0, sum_q} + (SUM_W+1)'(alp_rd_q);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (x_wrap && y_wrap && z_wrap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vox_v_q     <= 1'b0;
      alp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vox_v_q <= vox_re;
      alp_v_q <= vox_v_q;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan counters, running sum and result register
  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_x_q <= entry_i.lo_x;
      cur_y_q <= entry_i.lo_y;
      cur_z_q <= entry_i.lo_z;
      lo_y_q  <= entry_i.lo_y;
      lo_z_q  <= entry_i.lo_z;
      hi_x_q  <= entry_i.hi_x;
      hi_y_q  <= entry_i.hi_y;
      hi_z_q  <= entry_i.hi_z;
    end else if (state_q == ST_SCAN) begin
      if (!z_wrap) begin
        cur_z_q <= z_nx[CRD_W-1:0];
      end else begin
        cur_z_q <= lo_z_q;
        if (!y_wrap) begin
          cur_y_q <= y_nx[CRD_W-1:0];
        end else begin
          cur_y_q <= lo_y_q;
          if (!x_wrap) begin
            cur_x_q <= x_nx[CRD_W-1:0];
          end
        end
      end
    end
    if (start) begin
      sum_q <= '0;
    end else if (alp_v_q) begin
      sum_q <= sum_sat;
    end
    if (finish) begin
      out_sum_q <= sum_q;
      out_occ_q <= (sum_q != '0);
    end
  end

  // Voxel store: one write or one read a cycle, registered read
  always_ff @(posedge clk_i) begin
    if (vox_we) begin
      voxel_mem[wr_addr] <= entry_i.value;
    end
    if (vox_re) begin
      vox_rd_q <= voxel_mem[rd_addr];
    end
  end

  // Alpha table, looked up with the voxel byte just read
  always_ff @(posedge clk_i) begin
    if (alp_we) begin
      alpha_mem[entry_i.lo_x[VAL_W-1:0]] <= entry_i.value;
    end
    if (vox_v_q) begin
      alp_rd_q <= alpha_mem[vox_rd_q];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.opacity_sum = out_sum_q;
  assign out_o.occupied    = out_occ_q;

endmodule

`default_nettype wire

// ===== hdl/empty_space_cell_occupancy.sv =====
// A cell test passes front stages 1 and 2 and the queue; the back end scans its
// samples (1 to 8 voxels at default sizes) via voxel read, alpha lookup and sum
// into a registered result. A write takes effect when popped. No pop happens during
// a test; samples share the voxel store's single read port. The front end takes one
// item a cycle while its queue has room. Reset clears control state and sets each
// size register to 1; voxel store and alpha table are undefined until written.
`default_nettype none

module empty_space_cell_occupancy #(
  parameter int unsigned MAX_DIM     = esco_pkg::MAX_DIM_DEF,
  parameter int unsigned GRID        = esco_pkg::GRID_DEF,
  parameter int unsigned QUEUE_DEPTH = esco_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  esco_cfg_if.sink   cfg_i,
  esco_in_if.sink    in_i,
  esco_out_if.source out_o
);
  import esco_pkg::*;

  logic [CFG_W-1:0] vol_width_q;
  logic [CFG_W-1:0] vol_height_q;
  logic [CFG_W-1:0] vol_depth_q;
  logic [DIM_W-1:0] dim_x, dim_y, dim_z;

  logic             push;
  logic             pop;
  q_entry_t         front_entry;
  q_entry_t         head_entry;
  q_stat_t          qstat;

  // Size registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_width_q  <= CFG_W'(1);
      vol_height_q <= CFG_W'(1);
      vol_depth_q  <= CFG_W'(1);
    end else if (cfg_i.valid) begin
      case (reg_e'(cfg_i.index))
        REG_WIDTH: begin
          vol_width_q <= cfg_i.data;
        end
        REG_HEIGHT: begin
          vol_height_q <= cfg_i.data;
        end
        REG_DEPTH: begin
          vol_depth_q <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  // Effective sizes
  assign dim_x = eff_dim(vol_width_q, DIM_W'(MAX_DIM));
  assign dim_y = eff_dim(vol_height_q, DIM_W'(MAX_DIM));
  assign dim_z = eff_dim(vol_depth_q, DIM_W'(MAX_DIM));

  esco_front #(
    .MAX_DIM (MAX_DIM),
    .GRID    (GRID)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .dim_x_i (dim_x),
    .dim_y_i (dim_y),
    .dim_z_i (dim_z),
    .push_o  (push),
    .entry_o (front_entry),
    .qstat_i (qstat)
  );

  esco_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (qstat)
  );

  esco_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .qstat_i (qstat),
    .pop_o   (pop),
    .dim_x_i (dim_x),
    .dim_y_i (dim_y),
    .dim_z_i (dim_z),
    .out_o   (out_o)
  );

  // Queue is never written while full nor read while empty
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

  // Occupied flag agrees with the sum it travels with
  a_occupied_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.occupied == (out_o.opacity_sum != '0)))
    else $error("occupied flag disagrees with opacity sum");

endmodule

`default_nettype wire
